// ----- design/fbfa_pkg.sv -----
package fbfa_pkg;

  // Pool geometry
  localparam int POOL_BYTES = 4096;
  localparam int MIN_BLOCK  = 16;
  localparam int LINK_DEPTH = POOL_BYTES / MIN_BLOCK;

  // Field widths
  localparam int ADDR_W   = 12;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 13;
  localparam int IDX_W    = $clog2(LINK_DEPTH + 1);
  localparam int LINK_AW  = $clog2(LINK_DEPTH);
  localparam int CNT_W    = IDX_W;

  // Stream packing
  localparam int IN_DATA_W  = ((ADDR_W + 7) / 8) * 8;
  localparam int OUT_BITS   = ADDR_W + STATUS_W + CNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [0:0] {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_REJECT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic              start;
    logic [SIZE_W-1:0] dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [IDX_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- design/fbfa_link_ram.sv -----
module fbfa_link_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/fbfa_div.sv -----
module fbfa_div (
  input  logic               clk,
  input  logic               rst,
  input  fbfa_pkg::div_req_t req,
  output fbfa_pkg::div_rsp_t rsp
);

  import fbfa_pkg::*;

  localparam int DSH_W = SIZE_W + IDX_W - 1;
  localparam int STEP_W = $clog2(IDX_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [SIZE_W-1:0] rem;
  logic [DSH_W-1:0]  dsh;
  logic [IDX_W-1:0]  quo;
  logic              fits;

  // One quotient bit per cycle, most significant first
  assign fits = {{(DSH_W-SIZE_W){1'b0}}, rem} >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      step <= STEP_W'(IDX_W - 1);
    end else if (busy) begin
      step <= step - 1'b1;
      if (step == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend;
      dsh <= {req.divisor, {(IDX_W-1){1'b0}}};
      quo <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh[SIZE_W-1:0];
      end
      dsh <= dsh >> 1;
      quo <= {quo[IDX_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.quotient = quo;

endmodule

// ----- design/fixed_block_free_list_allocator_top.sv -----
// Fixed-size block free-list allocator.
//
// Input stream (s_*): one item per request. s_tuser carries req_type
// (0 allocate, 1 free), s_tdata carries the byte offset of a freed block.
// Output stream (m_*): one item per request with the allocated offset,
// a status code (ok, pool empty, free rejected) and the free block count.
// Config channel (cfg_*): writing the block size restarts the pool with
// every block free in address order; it is taken only when the block is idle.
//
// Request flow: an allocate takes a pop step, in which the link of the head
// block comes from a synchronous RAM read. A free and a config write pass
// through a bit-serial divider that maps a byte offset to a block index (for a
// config write, the pool bytes to a block count): either one holds the block
// until the divider is done. No new item is taken until the last is through.
// Reset: block size 16, 256 free blocks, head at block 0. The link RAM is
// not cleared; a valid bit per entry marks the entries a free has written,
// and an unwritten entry links to the next block in address order.
// Output stall: a result sits in the output register; the next item is
// accepted meanwhile and is held at its last step until the register frees.
module fixed_block_free_list_allocator_top (
  input  logic                            clk,
  input  logic                            rst,
  // slave side
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [fbfa_pkg::IN_DATA_W-1:0]  s_tdata,   // [11:0] free_addr
  input  logic [0:0]                      s_tuser,   // [0] req_type
  // master side
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [fbfa_pkg::OUT_DATA_W-1:0] m_tdata,   // [11:0] addr, [13:12] status,
                                                     // [22:14] free_blocks
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fbfa_pkg::SIZE_W-1:0]     cfg_data   // block_size
);

  import fbfa_pkg::*;

  localparam int PROD_W = IDX_W + SIZE_W;

  // Control and pool registers
  state_t            state, state_next;
  logic              is_cfg, is_cfg_next;
  logic [SIZE_W-1:0] eff_size, eff_size_next;
  logic [IDX_W-1:0]  head, head_next;         // head block index
  logic [CNT_W-1:0]  free_total, free_total_next;
  logic [CNT_W-1:0]  block_total, block_total_next;
  logic [LINK_DEPTH-1:0] linked;              // link entry written since restart

  // Output register
  logic                out_valid, out_valid_next;
  logic [ADDR_W-1:0]   out_addr, out_addr_next;
  status_t             out_status, out_status_next;
  logic [CNT_W-1:0]    out_free, out_free_next;

  logic              out_open;
  logic              cfg_take;
  logic [SIZE_W-1:0] size_clamped;
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  idx;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic               mem_we, mem_re;
  logic [LINK_AW-1:0] mem_waddr;
  logic [IDX_W-1:0]   mem_wdata;
  logic [IDX_W-1:0]   mem_rdata;

  fbfa_link_ram #(
    .DEPTH (LINK_DEPTH),
    .WIDTH (IDX_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (head[LINK_AW-1:0]),
    .rdata (mem_rdata)
  );

  fbfa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Clamp the written size into the legal block range
  always_comb begin
    if (cfg_data < SIZE_W'(MIN_BLOCK)) begin
      size_clamped = SIZE_W'(MIN_BLOCK);
    end else if (cfg_data > SIZE_W'(POOL_BYTES)) begin
      size_clamped = SIZE_W'(POOL_BYTES);
    end else begin
      size_clamped = cfg_data;
    end
  end

  assign out_open  = !out_valid || m_tready;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign prod      = PROD_W'(head) * PROD_W'(eff_size);
  assign idx       = div_rsp.quotient;
  assign cfg_ready = (state == ST_IDLE);
  assign s_tready  = (state == ST_IDLE) && !cfg_valid;

  always_comb begin
    state_next       = state;
    is_cfg_next      = is_cfg;
    eff_size_next    = eff_size;
    head_next        = head;
    free_total_next  = free_total;
    block_total_next = block_total;
    out_valid_next   = out_valid && !m_tready;
    out_addr_next    = out_addr;
    out_status_next  = out_status;
    out_free_next    = out_free;
    div_req          = '0;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    mem_waddr        = idx[LINK_AW-1:0];
    mem_wdata        = head;

    case (state)
      ST_IDLE: begin
        if (cfg_valid) begin
          // Restart: block count = pool bytes over block size
          eff_size_next    = size_clamped;
          div_req.start    = 1'b1;
          div_req.dividend = SIZE_W'(POOL_BYTES);
          div_req.divisor  = size_clamped;
          is_cfg_next      = 1'b1;
          state_next       = ST_DIV;
        end else if (s_tvalid) begin
          if (req_t'(s_tuser[0]) == REQ_ALLOC) begin
            mem_re     = 1'b1;
            state_next = ST_POP;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = SIZE_W'(s_tdata[ADDR_W-1:0]);
            div_req.divisor  = eff_size;
            is_cfg_next      = 1'b0;
            state_next       = ST_DIV;
          end
        end
      end

      ST_POP: begin
        if (out_open) begin
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
          if (free_total == '0) begin
            out_addr_next   = '0;
            out_status_next = STAT_EMPTY;
            out_free_next   = free_total;
          end else begin
            // An entry no free has written since the restart still links
            // to the next block in address order.
            if (linked[head[LINK_AW-1:0]]) begin
              head_next = mem_rdata;
            end else begin
              head_next = head + 1'b1;
            end
            free_total_next = free_total - 1'b1;
            out_addr_next   = prod[ADDR_W-1:0];
            out_status_next = STAT_OK;
            out_free_next   = free_total - 1'b1;
          end
        end
      end

      ST_DIV: begin
        if (!div_rsp.busy) begin
          if (is_cfg) begin
            block_total_next = idx;
            free_total_next  = idx;
            head_next        = '0;
            state_next       = ST_IDLE;
          end else if (out_open) begin
            out_valid_next = 1'b1;
            out_addr_next  = '0;
            state_next     = ST_IDLE;
            if (free_total >= block_total || idx >= block_total) begin
              out_status_next = STAT_REJECT;
              out_free_next   = free_total;
            end else begin
              // Push: link the block to the old head
              mem_we          = 1'b1;
              head_next       = idx;
              free_total_next = free_total + 1'b1;
              out_status_next = STAT_OK;
              out_free_next   = free_total + 1'b1;
            end
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      is_cfg      <= 1'b0;
      eff_size    <= SIZE_W'(MIN_BLOCK);
      head        <= '0;
      free_total  <= CNT_W'(POOL_BYTES / MIN_BLOCK);
      block_total <= CNT_W'(POOL_BYTES / MIN_BLOCK);
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      is_cfg      <= is_cfg_next;
      eff_size    <= eff_size_next;
      head        <= head_next;
      free_total  <= free_total_next;
      block_total <= block_total_next;
      out_valid   <= out_valid_next;
    end
  end

  // Mark a link entry once a push writes it; a restart drops every mark
  always_ff @(posedge clk) begin
    if (rst || cfg_take) begin
      linked <= '0;
    end else if (mem_we) begin
      linked[mem_waddr] <= 1'b1;
    end
  end

  // Payload holds while the receiver stalls
  always_ff @(posedge clk) begin
    out_addr   <= out_addr_next;
    out_status <= out_status_next;
    out_free   <= out_free_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W-OUT_BITS){1'b0}}, out_free, out_status, out_addr};

endmodule

// ----- tb/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fbfa_pkg::*;

  // One result item as it appears on m_tdata, lowest field last.
  typedef struct packed {
    logic              pad;
    logic [CNT_W-1:0]  free_blocks;
    status_t           status;
    logic [ADDR_W-1:0] addr;
  } reply_t;

  // Shadow of the pool: tracks the free list exactly and queues the reply
  // each accepted request must produce.
  class pool_scoreboard;
    int unsigned unit;
    int unsigned link_of[LINK_DEPTH];
    int unsigned head;
    int unsigned free_cnt;
    int unsigned total;
    int unsigned on_loan[$];
    reply_t      replies_due[$];
    int          faults;
    int          n_requests;
    int          n_ok;
    int          n_empty;
    int          n_reject;

    function new();
      restart(SIZE_W'(16));
    endfunction

    // Block size write: clamp the size, rebuild the chain in address order.
    function void restart(logic [SIZE_W-1:0] size_in);
      unit = size_in;
      if (unit < MIN_BLOCK) unit = MIN_BLOCK;
      if (unit > POOL_BYTES) unit = POOL_BYTES;
      total = POOL_BYTES / unit;
      if (total > LINK_DEPTH) total = LINK_DEPTH;
      free_cnt = total;
      head = 0;
      for (int i = 0; i < LINK_DEPTH; i++) link_of[i] = ((i + 1) * unit) & 32'h1FFFF;
      on_loan.delete();
    endfunction

    // Apply one accepted request and queue its reply.
    function void note_request(req_t kind, logic [ADDR_W-1:0] offset);
      reply_t      r;
      int unsigned slot;
      r = '0;
      r.status = STAT_OK;
      if (kind == REQ_ALLOC) begin
        if (free_cnt == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          slot = head / unit;
          r.addr = head[ADDR_W-1:0];
          on_loan.push_back(head);
          head = (slot < LINK_DEPTH) ? link_of[slot] : 0;
          free_cnt--;
        end
      end else begin
        slot = offset / unit;
        if (free_cnt >= total || slot >= total) begin
          r.status = STAT_REJECT;
        end else begin
          link_of[slot] = head;
          head = (slot * unit) & 32'h1FFFF;
          free_cnt++;
          for (int i = 0; i < on_loan.size(); i++) begin
            if (on_loan[i] == head) begin
              on_loan.delete(i);
              break;
            end
          end
        end
      end
      r.free_blocks = free_cnt[CNT_W-1:0];
      n_requests++;
      case (r.status)
        STAT_OK:    n_ok++;
        STAT_EMPTY: n_empty++;
        default:    n_reject++;
      endcase
      replies_due.push_back(r);
    endfunction

    // Compare one accepted result with the oldest queued reply.
    function void check_reply(logic [OUT_DATA_W-1:0] word);
      reply_t got;
      reply_t want;
      got = word;
      if (replies_due.size() == 0) begin
        faults++;
        if (faults <= 10) $display("ERROR: result %h arrived with no request pending", word);
        return;
      end
      want = replies_due.pop_front();
      if (got.addr !== want.addr || got.status !== want.status ||
          got.free_blocks !== want.free_blocks) begin
        faults++;
        if (faults <= 10)
          $display("ERROR: expected addr %0d status %0d free %0d, got addr %0d status %0d free %0d",
                   want.addr, want.status, want.free_blocks,
                   got.addr, got.status, got.free_blocks);
      end
    endfunction

    function int pending();
      return replies_due.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [SIZE_W-1:0]     cfg_data = '0;

  pool_scoreboard board;
  bit             sender_idles = 1'b1;
  bit             receiver_idles = 1'b1;
  int unsigned    hold_cycles = 0;
  int             size_writes = 0;

  always #10 clk = ~clk;

  fixed_block_free_list_allocator_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Watch all three channels at the edge; check the older result before
  // noting a new request, and restart the shadow pool on a size write.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_reply(m_tdata);
      if (s_tvalid && s_tready) board.note_request(req_t'(s_tuser), s_tdata[ADDR_W-1:0]);
      if (cfg_valid && cfg_ready) board.restart(cfg_data);
    end
  end

  // Result side: draw a stall per item, plus any long hold-off requested.
  initial begin
    int unsigned stall;
    forever begin
      stall = (receiver_idles ? $urandom_range(0, 11) : 0) + hold_cycles;
      hold_cycles = 0;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Offer one item after a random gap; return at the edge that takes it.
  // Leave tvalid high so the next item can follow without a bubble.
  task automatic send_request(req_t kind, logic [ADDR_W-1:0] offset);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= IN_DATA_W'(offset);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop offering, let the last taken item reach the scoreboard, wait for
  // every reply, then let any divider pass settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Write the block size once the block is idle.
  task automatic write_block_size(logic [SIZE_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    size_writes++;
  endtask

  initial begin
    int unsigned phase_size[9];
    int          phase_len[9];
    int          phase_alloc_pct[9];
    int unsigned offset;

    board = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset geometry, 16-byte blocks: pop in address order, return
    // misaligned offsets, refill the pool and hit the full rejection.
    send_request(REQ_ALLOC, 12'hFFF);
    send_request(REQ_ALLOC, 12'h000);
    send_request(REQ_ALLOC, 12'h000);
    send_request(REQ_FREE, 12'd21);
    send_request(REQ_FREE, 12'd0);
    send_request(REQ_FREE, 12'd47);
    send_request(REQ_FREE, 12'd0);
    send_request(REQ_ALLOC, 12'h000);

    // Oversized request clamps to one block covering the whole region.
    write_block_size(SIZE_W'(8191));
    send_request(REQ_ALLOC, 12'h000);
    send_request(REQ_ALLOC, 12'hFFF);
    send_request(REQ_FREE, 12'hFFF);
    send_request(REQ_FREE, 12'h000);

    // Four 1000-byte blocks leave a tail that no block covers.
    write_block_size(SIZE_W'(1000));
    send_request(REQ_ALLOC, 12'h000);
    send_request(REQ_FREE, 12'hFFF);
    send_request(REQ_FREE, 12'd999);
    send_request(REQ_FREE, 12'd0);

    // Undersized request clamps up to the minimum, then an odd size.
    write_block_size(SIZE_W'(15));
    send_request(REQ_ALLOC, 12'h000);
    write_block_size(SIZE_W'(17));
    send_request(REQ_ALLOC, 12'h000);
    send_request(REQ_FREE, 12'd4080);
    send_request(REQ_FREE, 12'd16);

    // Random phases; the first drains a 256-block pool past empty.
    phase_size      = '{0, 100, 17, 512, 4096, 4097, 16, 16, 1000};
    phase_len       = '{280, 70, 60, 60, 30, 20, 70, 70, 40};
    phase_alloc_pct = '{97, 60, 50, 50, 50, 50, 55, 55, 50};
    phase_size[6] = $urandom_range(16, 4096);
    phase_size[7] = $urandom_range(16, 600);

    foreach (phase_size[p]) begin
      write_block_size(SIZE_W'(phase_size[p]));
      // Hold results back while items keep streaming in to back up the block.
      if (p == 1) hold_cycles = 300;
      for (int i = 0; i < phase_len[p]; i++) begin
        if (i % 40 == 0) begin
          sender_idles   = (p != 1) && ($urandom_range(0, 3) != 0);
          receiver_idles = $urandom_range(0, 3) != 0;
        end
        if ($urandom_range(1, 100) <= phase_alloc_pct[p]) begin
          send_request(REQ_ALLOC, ADDR_W'($urandom_range(0, 4095)));
        end else begin
          // Mostly return a block on loan, sometimes somewhere inside it;
          // otherwise throw a random offset at the pool.
          if (board.on_loan.size() != 0 && $urandom_range(0, 9) != 0) begin
            offset = board.on_loan[$urandom_range(0, board.on_loan.size() - 1)];
            if ($urandom_range(0, 1) != 0) offset += $urandom_range(0, board.unit - 1);
          end else begin
            offset = $urandom_range(0, 4095);
          end
          send_request(REQ_FREE, ADDR_W'(offset));
        end
      end
    end

    drain();
    $display("Run covered %0d requests across %0d block size writes:", board.n_requests,
             size_writes);
    $display("  %0d ok, %0d allocations on an empty pool, %0d rejected frees",
             board.n_ok, board.n_empty, board.n_reject);
    if (board.faults == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", board.faults);
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: generous bound on the slowest legal run.
  initial begin
    #10_000_000;
    $display("Timed out waiting for the block");
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
design/fbfa_pkg.sv
design/fbfa_link_ram.sv
design/fbfa_div.sv
design/fixed_block_free_list_allocator_top.sv
tb/tb.sv
